/* rtl/core/cafe_pkg.sv */
// Shared types, widths and constants for the compliant arm force estimator.
package cafe_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    localparam int CFGW  = 32;  // config data width
    localparam int PRODW = 49;  // 33s x 16s products
    localparam int SPW   = 34;  // spring force, Q16.16
    localparam int LATW  = 36;  // lateral force, Q16.16
    localparam int ZW    = 33;  // angle, Q30
    localparam int XW    = 33;  // cos/sin, Q30
    localparam int PPW   = SPW + 17;        // partial products
    localparam int SUMW  = SPW + XW + 1;    // full product plus rounding
    localparam int RW    = SUMW - 30;       // product after rounding shift
    localparam int SATW  = RW + 1;          // after subtracting lateral force

    localparam logic signed [ZW-1:0] PI_Q30      = 33'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [XW-1:0] K_Q30       = 33'sd652032874;

    localparam logic [30:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

    localparam logic CFG_LIN_STIFF = 1'b0;
    localparam logic CFG_LAT_GAIN  = 1'b1;

    typedef struct packed {
        logic [63:0]        timestamp;
        logic signed [15:0] joint_angle;
        logic signed [15:0] lin_pos;
    } t_in;

    typedef struct packed {
        logic [63:0]          ts;
        logic signed [LATW-1:0] lat;
        logic signed [SPW-1:0]  spring;
    } t_side;

    typedef struct packed {
        t_side                side;
        logic signed [ZW-1:0] z;
    } t_front;

    typedef struct packed {
        t_side                side;
        logic signed [XW-1:0] cosv;
        logic signed [XW-1:0] sinv;
    } t_rot;

    typedef struct packed {
        logic [63:0]        stamp_out;
        logic signed [31:0] force_z;
        logic signed [31:0] force_y;
    } t_out;

    function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
        logic [SATW-32:0] top;
        top = v[SATW-1:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end else if (v[SATW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

/* rtl/core/cafe_front.sv */
// Front pipeline: stiffness products, rounding, half-turn angle reduction.
module cafe_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cafe_pkg::CFGW-1:0]  i_lin_stiff,
    input  logic [cafe_pkg::CFGW-1:0]  i_lat_gain,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cafe_pkg::t_in              i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output cafe_pkg::t_front           o_data
);

    localparam int PW  = cafe_pkg::PRODW;
    localparam int SW  = cafe_pkg::SPW;
    localparam int LW  = cafe_pkg::LATW;
    localparam int ZW  = cafe_pkg::ZW;
    localparam logic signed [PW-1:0] RND_S = PW'(1) <<< (PW - SW - 1);
    localparam logic signed [PW-1:0] RND_L = PW'(1) <<< (PW - LW - 1);

    logic [2:0] r_vld;
    logic [2:0] w_en;

    // stage 1
    logic signed [PW-1:0] r_prod_s, r_prod_l;
    logic signed [15:0]   r_ang;
    logic [63:0]          r_ts1;
    // stage 2
    logic signed [SW-1:0] r_spring2;
    logic signed [LW-1:0] r_lat2;
    logic signed [ZW-1:0] r_z2;
    logic                 r_flip;
    logic [63:0]          r_ts2;
    // stage 3
    cafe_pkg::t_front     r_out;

    logic signed [PW-1:0] n_prod_s, n_prod_l, w_sum_s, w_sum_l;
    logic signed [ZW-1:0] w_z, n_z;
    logic                 n_flip;
    logic signed [SW-1:0] n_spring3;

    assign w_en[2] = !r_vld[2] || i_ready;
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_vld[2];
    assign o_data  = r_out;

    assign n_prod_s = $signed({{(PW-32){1'b0}}, i_lin_stiff}) * PW'(i_data.lin_pos);
    assign n_prod_l = $signed({{(PW-32){1'b0}}, i_lat_gain}) * PW'(i_data.joint_angle);

    assign w_sum_s = r_prod_s + RND_S;
    assign w_sum_l = r_prod_l + RND_L;
    assign w_z     = {r_ang, {(ZW-16){1'b0}}};

    always_comb begin
        n_z    = w_z;
        n_flip = 1'b0;
        if (w_z > cafe_pkg::HALF_PI_Q30) begin
            n_z    = w_z - cafe_pkg::PI_Q30;
            n_flip = 1'b1;
        end else if (w_z < -cafe_pkg::HALF_PI_Q30) begin
            n_z    = w_z + cafe_pkg::PI_Q30;
            n_flip = 1'b1;
        end
    end

    assign n_spring3 = r_flip ? -r_spring2 : r_spring2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_prod_s <= n_prod_s;
            r_prod_l <= n_prod_l;
            r_ang    <= i_data.joint_angle;
            r_ts1    <= i_data.timestamp;
        end
        if (w_en[1]) begin
            r_spring2 <= w_sum_s[PW-1:PW-SW];
            r_lat2    <= w_sum_l[PW-1:PW-LW];
            r_z2      <= n_z;
            r_flip    <= n_flip;
            r_ts2     <= r_ts1;
        end
        if (w_en[2]) begin
            r_out.side.spring <= n_spring3;
            r_out.side.lat    <= r_lat2;
            r_out.side.ts     <= r_ts2;
            r_out.z           <= r_z2;
        end
    end

endmodule

/* rtl/core/cafe_cordic.sv */
// Rotation-mode CORDIC, one register stage per micro-rotation.
module cafe_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cafe_pkg::t_front  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output cafe_pkg::t_rot    o_data
);

    localparam int N  = cafe_pkg::NSTG;
    localparam int XW = cafe_pkg::XW;
    localparam int ZW = cafe_pkg::ZW;

    logic                 r_vld [N];
    logic signed [XW-1:0] r_x   [N];
    logic signed [XW-1:0] r_y   [N];
    logic signed [ZW-1:0] r_z   [N];
    cafe_pkg::t_side      r_sd  [N];

    logic                 w_vin [N];
    logic                 w_en  [N+1];
    logic signed [XW-1:0] w_xin [N];
    logic signed [XW-1:0] w_yin [N];
    logic signed [ZW-1:0] w_zin [N];
    cafe_pkg::t_side      w_sdin[N];
    logic signed [XW-1:0] n_x   [N];
    logic signed [XW-1:0] n_y   [N];
    logic signed [ZW-1:0] n_z   [N];

    assign w_en[N] = i_ready;
    assign o_ready = w_en[0];
    assign o_valid = r_vld[N-1];
    assign o_data.side = r_sd[N-1];
    assign o_data.cosv = r_x[N-1];
    assign o_data.sinv = r_y[N-1];

    for (genvar g = 0; g < N; g++) begin : g_stg
        logic signed [XW-1:0] w_dx, w_dy;
        logic signed [ZW-1:0] w_at;

        if (g == 0) begin : g_first
            assign w_vin[g]  = i_valid;
            assign w_xin[g]  = cafe_pkg::K_Q30;
            assign w_yin[g]  = '0;
            assign w_zin[g]  = i_data.z;
            assign w_sdin[g] = i_data.side;
        end else begin : g_next
            assign w_vin[g]  = r_vld[g-1];
            assign w_xin[g]  = r_x[g-1];
            assign w_yin[g]  = r_y[g-1];
            assign w_zin[g]  = r_z[g-1];
            assign w_sdin[g] = r_sd[g-1];
        end

        assign w_en[g] = !r_vld[g] || w_en[g+1];
        assign w_dx    = w_yin[g] >>> g;
        assign w_dy    = w_xin[g] >>> g;
        assign w_at    = $signed({{(ZW-31){1'b0}}, cafe_pkg::ATAN_Q30[g]});
        assign n_x[g]  = w_zin[g][ZW-1] ? w_xin[g] + w_dx : w_xin[g] - w_dx;
        assign n_y[g]  = w_zin[g][ZW-1] ? w_yin[g] - w_dy : w_yin[g] + w_dy;
        assign n_z[g]  = w_zin[g][ZW-1] ? w_zin[g] + w_at : w_zin[g] - w_at;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (w_en[k]) begin
                r_x[k]  <= n_x[k];
                r_y[k]  <= n_y[k];
                r_z[k]  <= n_z[k];
                r_sd[k] <= w_sdin[k];
            end
        end
    end

endmodule

/* rtl/core/cafe_mult.sv */
// Force products: split multiply, rounding, lateral term and saturation.
module cafe_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cafe_pkg::t_rot  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cafe_pkg::t_out  o_data
);

    localparam int XW   = cafe_pkg::XW;
    localparam int PPW  = cafe_pkg::PPW;
    localparam int SUMW = cafe_pkg::SUMW;
    localparam int RW   = cafe_pkg::RW;
    localparam int SATW = cafe_pkg::SATW;
    localparam int LW   = cafe_pkg::LATW;
    localparam logic signed [SUMW-1:0] RND = SUMW'(1) <<< 29;

    logic [2:0] r_vld;
    logic [2:0] w_en;

    // stage 1: partial products, sin/cos split at bit 16
    logic signed [PPW-1:0] r_py_lo, r_py_hi, r_pz_lo, r_pz_hi;
    logic signed [LW-1:0]  r_lat1;
    logic [63:0]           r_ts1;
    // stage 2: rounded products
    logic signed [RW-1:0]  r_fy2, r_fz2;
    logic signed [LW-1:0]  r_lat2;
    logic [63:0]           r_ts2;
    // stage 3: output register
    cafe_pkg::t_out        r_out;

    logic signed [PPW-1:0]  n_py_lo, n_py_hi, n_pz_lo, n_pz_hi;
    logic signed [SUMW-1:0] w_sy, w_sz;
    logic signed [SATW-1:0] w_dy;

    assign w_en[2] = !r_vld[2] || i_ready;
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_vld[2];
    assign o_data  = r_out;

    assign n_py_lo = PPW'(i_data.side.spring) * PPW'($signed({1'b0, i_data.sinv[15:0]}));
    assign n_py_hi = PPW'(i_data.side.spring) * PPW'($signed(i_data.sinv[XW-1:16]));
    assign n_pz_lo = PPW'(i_data.side.spring) * PPW'($signed({1'b0, i_data.cosv[15:0]}));
    assign n_pz_hi = PPW'(i_data.side.spring) * PPW'($signed(i_data.cosv[XW-1:16]));

    assign w_sy = $signed({{(SUMW-PPW-16){r_py_hi[PPW-1]}}, r_py_hi, 16'b0})
                + $signed({{(SUMW-PPW){r_py_lo[PPW-1]}}, r_py_lo}) + RND;
    assign w_sz = $signed({{(SUMW-PPW-16){r_pz_hi[PPW-1]}}, r_pz_hi, 16'b0})
                + $signed({{(SUMW-PPW){r_pz_lo[PPW-1]}}, r_pz_lo}) + RND;

    assign w_dy = $signed({r_fy2[RW-1], r_fy2})
                - $signed({{(SATW-LW){r_lat2[LW-1]}}, r_lat2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_py_lo <= n_py_lo;
            r_py_hi <= n_py_hi;
            r_pz_lo <= n_pz_lo;
            r_pz_hi <= n_pz_hi;
            r_lat1  <= i_data.side.lat;
            r_ts1   <= i_data.side.ts;
        end
        if (w_en[1]) begin
            r_fy2  <= w_sy[SUMW-1:30];
            r_fz2  <= w_sz[SUMW-1:30];
            r_lat2 <= r_lat1;
            r_ts2  <= r_ts1;
        end
        if (w_en[2]) begin
            r_out.force_y   <= cafe_pkg::sat32(w_dy);
            r_out.force_z   <= cafe_pkg::sat32($signed({r_fz2[RW-1], r_fz2}));
            r_out.stamp_out <= r_ts2;
        end
    end

endmodule

/* rtl/core/compliant_arm_force_estimator.sv */
// Top level: config registers and the front, CORDIC and product pipelines.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: lin_pos, joint_angle, timestamp
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: force_y, force_z, stamp_out
//  cfg       in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while m_axis_tready is held high. The data path
// has three front stages, one stage per CORDIC rotation and three product stages.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output still lets upstream bubbles fill. Reset clears all valid bits
// and loads the register defaults.
module compliant_arm_force_estimator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [95:0]                s_axis_tdata,   // lin_pos, joint_angle, timestamp
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [127:0]               m_axis_tdata,   // force_y, force_z, stamp_out
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [cafe_pkg::CFGW-1:0]  i_cfg_data
);

    logic [cafe_pkg::CFGW-1:0] r_lin_stiff, r_lat_gain;

    cafe_pkg::t_in    w_in;
    cafe_pkg::t_front w_front;
    cafe_pkg::t_rot   w_rot;
    cafe_pkg::t_out   w_out;
    logic             w_f_vld, w_f_rdy, w_r_vld, w_r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_stiff <= 32'd65536;
            r_lat_gain  <= 32'd6554;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cafe_pkg::CFG_LIN_STIFF: r_lin_stiff <= i_cfg_data;
                cafe_pkg::CFG_LAT_GAIN:  r_lat_gain  <= i_cfg_data;
            endcase
        end
    end

    assign w_in = s_axis_tdata;

    cafe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lin_stiff (r_lin_stiff),
        .i_lat_gain  (r_lat_gain),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (w_in),
        .o_valid     (w_f_vld),
        .i_ready     (w_f_rdy),
        .o_data      (w_front)
    );

    cafe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  (w_front),
        .o_valid (w_r_vld),
        .i_ready (w_r_rdy),
        .o_data  (w_rot)
    );

    cafe_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r_vld),
        .o_ready (w_r_rdy),
        .i_data  (w_rot),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = w_out;

endmodule

/* rtl/core/cafe_chk.sv */
// Port-level checker for the force estimator, bound to the top level.
module cafe_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // empty output stage means every stage can advance
    a_rdy_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // output beat taken means the whole pipe advances
    a_rdy_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

endmodule

bind compliant_arm_force_estimator cafe_chk u_cafe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
